// ===== sv/ecsi_pkg.sv =====
// Shared widths, register indexes and control types for the edge cut intersect block.
package ecsi_pkg;

    // Fractional bits of the cut fraction and of the edge distance
    localparam int FRAC_BITS   = 16;
    // Coordinate width and difference width
    localparam int CRD_W       = 32;
    localparam int XW          = CRD_W + 1;
    // Cross product width: two XW-bit products and a difference, plus headroom
    localparam int CW          = 2 * XW + 2;
    // Quotient width and the width of the progress product
    localparam int QW          = FRAC_BITS + 1;
    localparam int PW          = CW + QW;
    // Serial step counts
    localparam int MUL_STEPS   = XW;
    localparam int DIV_STEPS   = QW;
    localparam int CNT_W       = $clog2(MUL_STEPS + 1);

    localparam int PROG_W      = 17;
    localparam int ID_W        = 32;
    localparam int SIDE_W      = 4;
    localparam int DIST_W      = 17;

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [QW-1:0] PROG_FULL = QW'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUT_START_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_START_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_END_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_END_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_PROGRESS = 3'd4;

    // Control of one serial cross product unit
    typedef struct packed {
        logic load;
        logic step;
        logic msb;
    } cross_ctl_t;

endpackage

// ===== sv/edge_cut_segment_intersect.sv =====
// Top level: tests polygon edges against the configured cutting segment.
//
// Usage: program the cut segment and the active fraction through the write
// port (cfg_wen, cfg_index, cfg_wdata) while the block is idle. Then stream
// one edge per transfer on the slave side; tlast marks the polygon's last edge.
// Each edge gives exactly one result on the master side: tuser carries the hit
// flag, tdata the node ids, side, distance along the edge and the polygon cut
// flag, and tlast marks the result of the last edge.
// Flow: an edge passes through the bit-serial cross product units (one
// multiplier bit per cycle), a state that normalizes signs, the restoring
// divider for the edge distance (the progress product runs alongside) and
// a final state that loads the result once the output register is free.
// The next edge is taken only when the block is back in idle after that
// load, so edges are not overlapped. A result held by a stalled receiver
// sits in the output register while the next edge is already being worked.
// Reset: registers return to a zero segment and full progress, the polygon
// hit flag clears and no result is pending.
module edge_cut_segment_intersect
    import ecsi_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // fields from bit 0: edge_start_x, edge_start_y, edge_end_x, edge_end_y,
    // start_node, end_node, side_index, zero fill
    input  logic [ecsi_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields from bit 0: hit_start_node, hit_end_node, hit_side, edge_distance,
    // polygon_cut, zero fill
    output logic [ecsi_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // fields from bit 0: hit
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wen,
    input  logic [ecsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecsi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_NORM = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CRD_W-1:0] cut_sx_reg, cut_sy_reg, cut_ex_reg, cut_ey_reg;
    logic        [PROG_W-1:0] prog_reg;
    logic                     any_hit_reg;
    logic        [CNT_W-1:0]  cnt_reg;

    logic [ID_W-1:0]   snode_reg, enode_reg;
    logic [SIDE_W-1:0] side_reg;
    logic              last_reg;

    logic [CW-1:0]          d_reg;
    logic signed [CW-1:0]   nt_reg;
    logic [CW:0]            r_reg;
    logic [QW-1:0]          q_reg;
    logic [PW-1:0]          pacc_reg, pmc_reg;
    logic [QW-1:0]          pmul_reg;
    logic                   pre_ok_reg;

    logic                   out_v_reg;
    logic                   out_hit_reg, out_last_reg, out_cut_reg;
    logic [ID_W-1:0]        out_snode_reg, out_enode_reg;
    logic [SIDE_W-1:0]      out_side_reg;
    logic [DIST_W-1:0]      out_dist_reg;

    logic accept, out_take, load_out;

    logic signed [CRD_W-1:0] ex0, ey0, ex1, ey1;
    logic signed [XW-1:0]    sdx, sdy, cdx, cdy, wx, wy;
    logic signed [CW-1:0]    d_raw, nt_raw, nu_raw;
    logic signed [CW-1:0]    dn, ntn, nun;
    logic [QW-1:0]           prog_sat;
    logic [CW:0]             rs, d_ext;
    logic                    ge;
    logic                    hit;
    cross_ctl_t              xctl;

    assign accept   = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Unpack input fields and form the direction and offset vectors
    always_comb
    begin
        ex0 = s_tdata[31:0];
        ey0 = s_tdata[63:32];
        ex1 = s_tdata[95:64];
        ey1 = s_tdata[127:96];
        sdx = {ex1[CRD_W-1], ex1} - {ex0[CRD_W-1], ex0};
        sdy = {ey1[CRD_W-1], ey1} - {ey0[CRD_W-1], ey0};
        cdx = {cut_ex_reg[CRD_W-1], cut_ex_reg} - {cut_sx_reg[CRD_W-1], cut_sx_reg};
        cdy = {cut_ey_reg[CRD_W-1], cut_ey_reg} - {cut_sy_reg[CRD_W-1], cut_sy_reg};
        wx  = {ex0[CRD_W-1], ex0} - {cut_sx_reg[CRD_W-1], cut_sx_reg};
        wy  = {ey0[CRD_W-1], ey0} - {cut_sy_reg[CRD_W-1], cut_sy_reg};
    end

    // Drive the three serial cross product units
    always_comb
    begin
        xctl.load = accept;
        xctl.step = (state_reg == S_MUL);
        xctl.msb  = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    end

    ecsi_cross u_cross_d (
        .clk  (clk),
        .ctl  (xctl),
        .a    (cdx),
        .b    (sdy),
        .c    (cdy),
        .d    (sdx),
        .prod (d_raw)
    );

    ecsi_cross u_cross_nt (
        .clk  (clk),
        .ctl  (xctl),
        .a    (wx),
        .b    (sdy),
        .c    (wy),
        .d    (sdx),
        .prod (nt_raw)
    );

    ecsi_cross u_cross_nu (
        .clk  (clk),
        .ctl  (xctl),
        .a    (wx),
        .b    (cdy),
        .c    (wy),
        .d    (cdx),
        .prod (nu_raw)
    );

    // Flip signs so the denominator is positive; saturate progress
    always_comb
    begin
        dn  = d_raw[CW-1] ? -d_raw  : d_raw;
        ntn = d_raw[CW-1] ? -nt_raw : nt_raw;
        nun = d_raw[CW-1] ? -nu_raw : nu_raw;
        prog_sat = (prog_reg > PROG_W'(PROG_FULL)) ? PROG_FULL : QW'(prog_reg);
    end

    // One restoring division step; the first step does not shift
    always_comb
    begin
        rs    = (cnt_reg == '0) ? r_reg : (r_reg << 1);
        d_ext = {1'b0, d_reg};
        ge    = (rs >= d_ext);
    end

    // Final hit test: the early checks pass and nt * 2^FRAC_BITS <= d * progress
    assign hit = pre_ok_reg &&
                 ((PW'(nt_reg[CW-2:0]) << FRAC_BITS) <= pacc_reg);

    assign load_out = (state_reg == S_DONE) && (!out_v_reg || m_tready);

    // Sequence one edge through multiply, normalize and divide
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_MUL;
            S_MUL:  if (xctl.msb) state_next = S_NORM;
            S_NORM: state_next = S_DIV;
            S_DIV:  if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and polygon flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            out_v_reg   <= 1'b0;
            any_hit_reg <= 1'b0;
            cut_sx_reg  <= '0;
            cut_sy_reg  <= '0;
            cut_ex_reg  <= '0;
            cut_ey_reg  <= '0;
            prog_reg    <= PROG_W'(PROG_FULL);
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_MUL && xctl.msb) ||
                (state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)))
                cnt_reg <= '0;
            else if (state_reg == S_MUL || state_reg == S_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            if (load_out)
            begin
                out_v_reg   <= 1'b1;
                any_hit_reg <= last_reg ? 1'b0 : (any_hit_reg || hit);
            end
            else if (out_take)
                out_v_reg <= 1'b0;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_CUT_START_X:  cut_sx_reg <= cfg_wdata;
                    REG_CUT_START_Y:  cut_sy_reg <= cfg_wdata;
                    REG_CUT_END_X:    cut_ex_reg <= cfg_wdata;
                    REG_CUT_END_Y:    cut_ey_reg <= cfg_wdata;
                    REG_CUT_PROGRESS: prog_reg   <= cfg_wdata[PROG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath: capture edge, normalize, divide, register the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snode_reg <= s_tdata[159:128];
            enode_reg <= s_tdata[191:160];
            side_reg  <= s_tdata[195:192];
            last_reg  <= s_tlast;
        end
        if (state_reg == S_NORM)
        begin
            d_reg      <= dn;
            nt_reg     <= ntn;
            r_reg      <= {1'b0, nun};
            q_reg      <= '0;
            pacc_reg   <= '0;
            pmc_reg    <= PW'(dn);
            pmul_reg   <= prog_sat;
            pre_ok_reg <= (d_raw != '0) && !ntn[CW-1] && !nun[CW-1] &&
                          (nun <= dn);
        end
        if (state_reg == S_DIV)
        begin
            r_reg    <= ge ? (rs - d_ext) : rs;
            q_reg    <= {q_reg[QW-2:0], ge};
            if (pmul_reg[0])
                pacc_reg <= pacc_reg + pmc_reg;
            pmc_reg  <= pmc_reg << 1;
            pmul_reg <= pmul_reg >> 1;
        end
        if (load_out)
        begin
            out_hit_reg   <= hit;
            out_snode_reg <= hit ? snode_reg : '0;
            out_enode_reg <= hit ? enode_reg : '0;
            out_side_reg  <= hit ? side_reg : '0;
            out_dist_reg  <= hit ? DIST_W'(q_reg) : '0;
            out_last_reg  <= last_reg;
            out_cut_reg   <= last_reg && (any_hit_reg || hit);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_cut_reg, out_dist_reg, out_side_reg,
                       out_enode_reg, out_snode_reg};

    // An accepted edge always starts the multiply phase
    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL)
        else $error("accepted edge did not start the multiply phase");

    // A miss carries zero payload fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[84:0] == '0)
        else $error("miss result carries nonzero fields");

    // A hit distance never exceeds one
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[84:68] <= 17'd65536)
        else $error("edge distance above one");

    // The divider never runs past its step count
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divider step count overrun");

endmodule

// ===== sv/ecsi_cross.sv =====
// Bit-serial signed cross product: prod = a*b - c*d; one multiplier bit per step cycle.
module ecsi_cross (
    input  logic                              clk,
    input  ecsi_pkg::cross_ctl_t              ctl,
    input  logic signed [ecsi_pkg::XW-1:0]    a,
    input  logic signed [ecsi_pkg::XW-1:0]    b,
    input  logic signed [ecsi_pkg::XW-1:0]    c,
    input  logic signed [ecsi_pkg::XW-1:0]    d,
    output logic signed [ecsi_pkg::CW-1:0]    prod
);
    import ecsi_pkg::*;

    logic signed [CW-1:0] a_sh_reg, c_sh_reg, acc_reg;
    logic        [XW-1:0] b_sh_reg, d_sh_reg;
    logic signed [CW-1:0] t1, t2;

    // Select partial products for the current multiplier bits
    always_comb
    begin
        t1 = b_sh_reg[0] ? a_sh_reg : '0;
        t2 = d_sh_reg[0] ? c_sh_reg : '0;
    end

    // Load operands, then shift and accumulate; the top bit weighs negative
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_sh_reg <= {{(CW-XW){a[XW-1]}}, a};
            c_sh_reg <= {{(CW-XW){c[XW-1]}}, c};
            b_sh_reg <= b;
            d_sh_reg <= d;
            acc_reg  <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.msb)
                acc_reg <= acc_reg - t1 + t2;
            else
                acc_reg <= acc_reg + t1 - t2;
            a_sh_reg <= a_sh_reg <<< 1;
            c_sh_reg <= c_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >> 1;
            d_sh_reg <= d_sh_reg >> 1;
        end
    end

    assign prod = acc_reg;

endmodule
